/* design/xs128_pkg.sv */
`timescale 1ns / 1ps

package xs128_pkg;

    localparam logic [31:0] SEED_MULT  = 32'h6C07_8965;
    localparam logic [31:0] RESET_SEED = 32'd42069;

    // Replacement set for an all-zero load
    localparam logic [31:0] ZERO_FIX_0 = 32'h0000_0001;
    localparam logic [31:0] ZERO_FIX_1 = 32'h6C07_8967;
    localparam logic [31:0] ZERO_FIX_2 = 32'h714A_CB41;
    localparam logic [31:0] ZERO_FIX_3 = 32'h4807_7044;

    localparam int SEED_SHIFT = 30;
    localparam int DRAW_SHL   = 11;
    localparam int DRAW_SHR_T = 8;
    localparam int DRAW_SHR_W = 19;

    typedef enum logic [1:0] {
        OP_SEED  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_DRAW1 = 2'd2,
        OP_DRAW2 = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_DRAW,
        ST_FINISH
    } seq_state_t;

    // Control handed from the sequencer to the shared step unit
    typedef struct packed {
        logic       draw;
        logic [2:0] k;
    } unit_ctrl_t;

    function automatic logic [31:0] seed_link(input logic [31:0] s, input logic [2:0] k);
        logic [31:0] mixed;
        mixed = s ^ (s >> SEED_SHIFT);
        return SEED_MULT * mixed + {29'd0, k};
    endfunction

    localparam logic [31:0] RESET_W0 = seed_link(RESET_SEED, 3'd1);
    localparam logic [31:0] RESET_W1 = seed_link(RESET_W0, 3'd2);
    localparam logic [31:0] RESET_W2 = seed_link(RESET_W1, 3'd3);
    localparam logic [31:0] RESET_W3 = seed_link(RESET_W2, 3'd4);

endpackage

/* design/xorshift128_rng_with_seeding_core.sv */
`timescale 1ns / 1ps

// Xorshift128 generator with single-word seeding and four-word load.
//
// Request channel: in_valid/in_ready carry opcode and seed_a..seed_d.
// Result channel: out_valid/out_ready carry random_value and the four
// state words as they stand after the request.
//
// One shared step unit (one 32x32 multiply-add for seeding, or one
// xor-shift for a draw) is stepped by a small sequencer, one step a cycle:
//   load       : no step, the words are written as the request is taken
//   draw 32    : 1 step
//   draw 64    : 2 steps
//   seed       : 4 chained multiply steps
// plus a finish state that moves the result into the output register once
// that register is free. in_ready stays low from the taking of a request
// until its result has moved, so no new request starts before then.
//
// The output register decouples the channels: a new request is taken while
// a finished result still waits. If the receiver stalls, the next result
// holds in the sequencer until the output register frees up.
//
// Reset puts the state at the value seeded from 42069, with no result
// pending; the block is ready in the first cycle after reset.
module xorshift128_rng_with_seeding_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] seed_a,
    input  logic [31:0] seed_b,
    input  logic [31:0] seed_c,
    input  logic [31:0] seed_d,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] random_value,
    output logic [31:0] state_word_0,
    output logic [31:0] state_word_1,
    output logic [31:0] state_word_2,
    output logic [31:0] state_word_3
);
    import xs128_pkg::*;

    seq_state_t  state_reg, state_next;
    logic [1:0]  step_cnt_reg, step_cnt_next;
    logic        wide_reg, wide_next;
    logic [31:0] link_reg, link_next;
    logic [63:0] value_reg, value_next;
    logic [31:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic [31:0] w0_next, w1_next, w2_next, w3_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_value_reg, out_value_next;
    logic [31:0] out_w0_reg, out_w1_reg, out_w2_reg, out_w3_reg;
    logic [31:0] out_w0_next, out_w1_next, out_w2_next, out_w3_next;

    unit_ctrl_t  unit_ctrl;
    logic [31:0] unit_result;
    logic        in_fire;
    logic        out_free;
    logic        load_zero;

    assign unit_ctrl = {(state_reg == ST_DRAW), {1'b0, step_cnt_reg} + 3'd1};

    xs128_unit u_unit (
        .ctrl   (unit_ctrl),
        .src    (link_reg),
        .word_0 (w0_reg),
        .word_3 (w3_reg),
        .result (unit_result)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign load_zero = ((seed_a | seed_b | seed_c | seed_d) == 32'd0);

    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        wide_next      = wide_reg;
        link_next      = link_reg;
        value_next     = value_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        w3_next        = w3_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_w0_next    = out_w0_reg;
        out_w1_next    = out_w1_reg;
        out_w2_next    = out_w2_reg;
        out_w3_next    = out_w3_reg;

        // Drop the pending result once the receiver takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    step_cnt_next = 2'd0;
                    value_next    = 64'd0;
                    wide_next     = (opcode_t'(opcode) == OP_DRAW2);
                    link_next     = seed_a;
                    case (opcode_t'(opcode))
                        OP_SEED:
                        begin
                            state_next = ST_SEED;
                        end
                        OP_LOAD:
                        begin
                            w0_next    = load_zero ? ZERO_FIX_0 : seed_a;
                            w1_next    = load_zero ? ZERO_FIX_1 : seed_b;
                            w2_next    = load_zero ? ZERO_FIX_2 : seed_c;
                            w3_next    = load_zero ? ZERO_FIX_3 : seed_d;
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_DRAW;
                        end
                    endcase
                end
            end
            ST_SEED:
            begin
                // Chain each link from the previous one into the next word
                link_next = unit_result;
                case (step_cnt_reg)
                    2'd0:    w0_next = unit_result;
                    2'd1:    w1_next = unit_result;
                    2'd2:    w2_next = unit_result;
                    default: w3_next = unit_result;
                endcase
                step_cnt_next = step_cnt_reg + 2'd1;
                if (step_cnt_reg == 2'd3)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DRAW:
            begin
                // Advance the state; a 64-bit draw puts its first word in the upper half
                w0_next       = w1_reg;
                w1_next       = w2_reg;
                w2_next       = w3_reg;
                w3_next       = unit_result;
                value_next    = {value_reg[31:0], unit_result};
                step_cnt_next = step_cnt_reg + 2'd1;
                if (!wide_reg || step_cnt_reg[0])
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = value_reg;
                    out_w0_next    = w0_reg;
                    out_w1_next    = w1_reg;
                    out_w2_next    = w2_reg;
                    out_w3_next    = w3_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg  <= 2'd0;
            wide_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            w0_reg        <= RESET_W0;
            w1_reg        <= RESET_W1;
            w2_reg        <= RESET_W2;
            w3_reg        <= RESET_W3;
        end
        else
        begin
            step_cnt_reg  <= step_cnt_next;
            wide_reg      <= wide_next;
            out_valid_reg <= out_valid_next;
            w0_reg        <= w0_next;
            w1_reg        <= w1_next;
            w2_reg        <= w2_next;
            w3_reg        <= w3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        link_reg      <= link_next;
        value_reg     <= value_next;
        out_value_reg <= out_value_next;
        out_w0_reg    <= out_w0_next;
        out_w1_reg    <= out_w1_next;
        out_w2_reg    <= out_w2_next;
        out_w3_reg    <= out_w3_next;
    end

    assign out_valid    = out_valid_reg;
    assign random_value = out_value_reg;
    assign state_word_0 = out_w0_reg;
    assign state_word_1 = out_w1_reg;
    assign state_word_2 = out_w2_reg;
    assign state_word_3 = out_w3_reg;

endmodule

/* design/xs128_unit.sv */
`timescale 1ns / 1ps

module xs128_unit (
    input  xs128_pkg::unit_ctrl_t ctrl,
    input  logic [31:0]           src,
    input  logic [31:0]           word_0,
    input  logic [31:0]           word_3,
    output logic [31:0]           result
);
    import xs128_pkg::*;

    logic [31:0] t;
    logic [31:0] draw_word;

    // xorshift step: new last word from first and last words
    assign t         = word_0 ^ (word_0 << DRAW_SHL);
    assign draw_word = t ^ (t >> DRAW_SHR_T) ^ word_3 ^ (word_3 >> DRAW_SHR_W);

    assign result = ctrl.draw ? draw_word : seed_link(src, ctrl.k);

endmodule

/* design/xs128_chk.sv */
`timescale 1ns / 1ps

module xs128_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] random_value,
    input logic [31:0] state_word_0,
    input logic [31:0] state_word_1,
    input logic [31:0] state_word_2,
    input logic [31:0] state_word_3
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(random_value)
            && $stable(state_word_3))
        else $error("stalled result changed");

    // Every accepted request makes the sequencer busy, so in_ready falls after it
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted back to back");

    // A new result only comes out of a busy sequencer
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request in flight");

    // The generator never reports an all-zero state
    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_word_0 | state_word_1 | state_word_2 | state_word_3) != 32'd0)
        else $error("all-zero generator state");

endmodule

bind xorshift128_rng_with_seeding_core xs128_chk u_xs128_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value),
    .state_word_0 (state_word_0),
    .state_word_1 (state_word_1),
    .state_word_2 (state_word_2),
    .state_word_3 (state_word_3)
);
